// ===== rtl/hcomp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hcomp_pkg
// shared widths, arctangent table and pipeline payload types for the
// magnetometer compass heading block
// ----------------------------------------------------------------------------
package hcomp_pkg;

  localparam int unsigned ANGLE_STAGES_DEF = 16;
  localparam int unsigned ARC_LEN          = 24;

  localparam int unsigned RAW_W  = 16;
  localparam int unsigned SPAN_W = 16;  // |high - low|
  localparam int unsigned MAG_W  = 17;  // |2*raw - low - high|
  localparam int unsigned PROD_W = 43;  // 1000 * mag * span
  localparam int unsigned NUM_W  = 28;  // 2000 * mag + span
  localparam int unsigned DEN_W  = 17;  // 2 * span
  localparam int unsigned QUO_W  = 16;
  localparam int unsigned REM_W  = 34;
  localparam int unsigned NORM_W = 60;
  localparam int unsigned NORM_STEPS = 6;
  localparam int unsigned CORD_W = 64;
  localparam int unsigned ANG_W  = 32;
  localparam int unsigned ANG_FRAC = 16;
  localparam int unsigned HEAD_W = 16;
  localparam int unsigned QANG_W = 14;

  localparam logic [ANG_W-1:0] ANG_ROUND = 32'd32768;
  localparam logic [QANG_W-1:0] QANG_MAX = 14'd9000;
  localparam logic [HEAD_W-1:0] HEAD_HALF = 16'd18000;
  localparam logic [HEAD_W-1:0] HEAD_FULL = 16'd36000;
  localparam logic [NUM_W-1:0] MAP_SCALE2 = 28'd2000;
  localparam logic [PROD_W-1:0] MAP_SCALE = 43'd1000;

  // atan(2^-i) in 1/65536 centidegree
  localparam logic [ANG_W-1:0] ARC_TABLE [ARC_LEN] = '{
    32'd294912000, 32'd174096719, 32'd91987925, 32'd46694507, 32'd23437865,
    32'd11730358, 32'd5866610, 32'd2933484, 32'd1466764, 32'd733385,
    32'd366693, 32'd183346, 32'd91673, 32'd45837, 32'd22918, 32'd11459,
    32'd5730, 32'd2865, 32'd1432, 32'd716, 32'd358, 32'd179, 32'd90, 32'd45
  };

  typedef enum logic [1:0] {
    REG_X_LOW  = 2'd0,
    REG_X_HIGH = 2'd1,
    REG_Y_LOW  = 2'd2,
    REG_Y_HIGH = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic neg_x;
    logic neg_y;
    logic zero_x;
    logic zero_y;
    logic err;
  } head_side_t;

  typedef struct packed {
    logic [PROD_W-1:0] ax;
    logic [PROD_W-1:0] ay;
    logic [NUM_W-1:0]  nx;
    logic [NUM_W-1:0]  ny;
    logic [DEN_W-1:0]  dx;
    logic [DEN_W-1:0]  dy;
    logic              ovf_x;
    logic              ovf_y;
    head_side_t        side;
  } front_t;

  typedef struct packed {
    logic [NORM_W-1:0] ax;
    logic [NORM_W-1:0] ay;
    head_side_t        side;
  } norm_t;

  typedef struct packed {
    logic signed [CORD_W-1:0] x;
    logic signed [CORD_W-1:0] y;
    logic signed [ANG_W-1:0]  z;
    head_side_t               side;
  } cord_t;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [QUO_W-1:0] quo;
    logic             ovf;
  } div_t;

endpackage
`default_nettype wire

// ===== rtl/hcomp_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hcomp_front
// span mapping and cross products, three register stages
// ----------------------------------------------------------------------------
module hcomp_front (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic signed [hcomp_pkg::RAW_W-1:0] raw_x_i,
  input  wire logic signed [hcomp_pkg::RAW_W-1:0] raw_y_i,
  input  wire logic signed [hcomp_pkg::RAW_W-1:0] x_low_i,
  input  wire logic signed [hcomp_pkg::RAW_W-1:0] x_high_i,
  input  wire logic signed [hcomp_pkg::RAW_W-1:0] y_low_i,
  input  wire logic signed [hcomp_pkg::RAW_W-1:0] y_high_i,
  output hcomp_pkg::front_t                  front_o
);
  import hcomp_pkg::*;

  logic signed [MAG_W:0]  sx, sy;
  logic signed [SPAN_W:0] dfx, dfy;
  logic [MAG_W:0]         sx_abs, sy_abs;
  logic [SPAN_W:0]        dfx_abs, dfy_abs;

  logic [MAG_W-1:0]  mx_q, my_q;
  logic [SPAN_W-1:0] xdm_q, ydm_q;
  head_side_t        side1_q, side2_q;

  logic [MAG_W+SPAN_W-1:0] px_q, py_q;
  logic [NUM_W-1:0]        nx_d, ny_d, nx_q, ny_q;
  logic [DEN_W-1:0]        dx_d, dy_d, dx_q, dy_q;
  logic                    ovfx_q, ovfy_q;

  front_t front_q;

  // stage 1: offsets from the span midpoint, span magnitudes
  assign sx  = ((MAG_W+1)'(raw_x_i) <<< 1) - (MAG_W+1)'(x_low_i) - (MAG_W+1)'(x_high_i);
  assign sy  = ((MAG_W+1)'(raw_y_i) <<< 1) - (MAG_W+1)'(y_low_i) - (MAG_W+1)'(y_high_i);
  assign dfx = (SPAN_W+1)'(x_high_i) - (SPAN_W+1)'(x_low_i);
  assign dfy = (SPAN_W+1)'(y_high_i) - (SPAN_W+1)'(y_low_i);
  assign sx_abs  = sx[MAG_W] ? -sx : sx;
  assign sy_abs  = sy[MAG_W] ? -sy : sy;
  assign dfx_abs = dfx[SPAN_W] ? -dfx : dfx;
  assign dfy_abs = dfy[SPAN_W] ? -dfy : dfy;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mx_q  <= sx_abs[MAG_W-1:0];
      my_q  <= sy_abs[MAG_W-1:0];
      xdm_q <= dfx_abs[SPAN_W-1:0];
      ydm_q <= dfy_abs[SPAN_W-1:0];
      side1_q.neg_x  <= (sx[MAG_W] ^ dfx[SPAN_W]) && (sx != '0);
      side1_q.neg_y  <= (sy[MAG_W] ^ dfy[SPAN_W]) && (sy != '0);
      side1_q.zero_x <= (sx == '0);
      side1_q.zero_y <= (sy == '0);
      side1_q.err    <= (dfx == '0) || (dfy == '0);
    end
  end

  // stage 2: cross products and divider operands
  assign nx_d = NUM_W'(mx_q) * MAP_SCALE2 + NUM_W'(xdm_q);
  assign ny_d = NUM_W'(my_q) * MAP_SCALE2 + NUM_W'(ydm_q);
  assign dx_d = {xdm_q, 1'b0};
  assign dy_d = {ydm_q, 1'b0};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q    <= (MAG_W+SPAN_W)'(mx_q) * (MAG_W+SPAN_W)'(ydm_q);
      py_q    <= (MAG_W+SPAN_W)'(my_q) * (MAG_W+SPAN_W)'(xdm_q);
      nx_q    <= nx_d;
      ny_q    <= ny_d;
      dx_q    <= dx_d;
      dy_q    <= dy_d;
      ovfx_q  <= (DEN_W+QUO_W)'(nx_d) >= {dx_d, QUO_W'(0)};
      ovfy_q  <= (DEN_W+QUO_W)'(ny_d) >= {dy_d, QUO_W'(0)};
      side2_q <= side1_q;
    end
  end

  // stage 3: common scale of the vector components
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      front_q.ax    <= PROD_W'(px_q) * MAP_SCALE;
      front_q.ay    <= PROD_W'(py_q) * MAP_SCALE;
      front_q.nx    <= nx_q;
      front_q.ny    <= ny_q;
      front_q.dx    <= dx_q;
      front_q.dy    <= dy_q;
      front_q.ovf_x <= ovfx_q;
      front_q.ovf_y <= ovfy_q;
      front_q.side  <= side2_q;
    end
  end

  assign front_o = front_q;

endmodule
`default_nettype wire

// ===== rtl/hcomp_div_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hcomp_div_cell
// one restoring division step, settles one quotient bit
// ----------------------------------------------------------------------------
module hcomp_div_cell #(
  parameter int unsigned BIT = 0
) (
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  hcomp_pkg::div_t      div_i,
  output hcomp_pkg::div_t      div_o
);
  import hcomp_pkg::*;

  logic [REM_W-1:0] dsh;
  logic             take;
  logic [QUO_W-1:0] quo_d;
  div_t             div_q;

  assign dsh   = REM_W'(div_i.den) << BIT;
  assign take  = div_i.rem >= dsh;
  assign quo_d = div_i.quo | (QUO_W'(take) << BIT);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      div_q.rem <= take ? div_i.rem - dsh : div_i.rem;
      div_q.den <= div_i.den;
      div_q.quo <= quo_d;
      div_q.ovf <= div_i.ovf;
    end
  end

  assign div_o = div_q;

endmodule
`default_nettype wire

// ===== rtl/hcomp_norm_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hcomp_norm_cell
// one step of the leading-zero normalizer, shifts both components together
// ----------------------------------------------------------------------------
module hcomp_norm_cell #(
  parameter int unsigned SHIFT = 1
) (
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  hcomp_pkg::norm_t     norm_i,
  output hcomp_pkg::norm_t     norm_o
);
  import hcomp_pkg::*;

  logic [NORM_W-1:0] m;
  logic              sh;
  norm_t             norm_q;

  assign m  = norm_i.ax | norm_i.ay;
  assign sh = (m[NORM_W-1 -: SHIFT] == '0);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      norm_q.ax   <= sh ? norm_i.ax << SHIFT : norm_i.ax;
      norm_q.ay   <= sh ? norm_i.ay << SHIFT : norm_i.ay;
      norm_q.side <= norm_i.side;
    end
  end

  assign norm_o = norm_q;

endmodule
`default_nettype wire

// ===== rtl/hcomp_cordic_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hcomp_cordic_cell
// one vectoring rotation, drives y toward zero and accumulates the angle
// ----------------------------------------------------------------------------
module hcomp_cordic_cell #(
  parameter int unsigned STAGE = 0
) (
  input  wire logic            clk_i,
  input  wire logic            en_i,
  input  hcomp_pkg::cord_t     cord_i,
  output hcomp_pkg::cord_t     cord_o
);
  import hcomp_pkg::*;

  localparam logic signed [ANG_W-1:0] ARC = ARC_TABLE[STAGE];

  logic signed [CORD_W-1:0] dx, dy;
  cord_t                    cord_q;

  // arithmetic shift floors negative values
  assign dx = cord_i.y >>> STAGE;
  assign dy = cord_i.x >>> STAGE;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (!cord_i.y[CORD_W-1]) begin
        cord_q.x <= cord_i.x + dx;
        cord_q.y <= cord_i.y - dy;
        cord_q.z <= cord_i.z + ARC;
      end else begin
        cord_q.x <= cord_i.x - dx;
        cord_q.y <= cord_i.y + dy;
        cord_q.z <= cord_i.z - ARC;
      end
      cord_q.side <= cord_i.side;
    end
  end

  assign cord_o = cord_q;

endmodule
`default_nettype wire

// ===== rtl/compass_heading_from_magnetometer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// compass_heading_from_magnetometer
// calibrated compass heading (atan2) and mapped axes from one raw sample
// ----------------------------------------------------------------------------
//
//   port group   dir   contents
//   s_axis_*     in    raw sample request (raw_x, raw_y)
//   m_axis_*     out   heading and mapped axes per sample
//   cfg_*        in    span register writes, no read-back
//
// one sample per cycle sustained while the output is taken; the row is
// three front stages, six normalizer steps plus one cell per
// arctangent stage in parallel with sixteen divider cells, one output stage
// the whole row moves on one enable; it holds only while a result sits in
// the output register and the consumer does not take it
// reset clears valid bits and loads the spans to the full 16-bit range
//
module compass_heading_from_magnetometer #(
  parameter int unsigned ANGLE_STAGES = hcomp_pkg::ANGLE_STAGES_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // raw_x [15:0], raw_y [31:16]
  input  wire logic [31:0] s_axis_tdata,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // heading_centideg [15:0], cal_x [31:16], cal_y [47:32],
  // cal_saturated [48], cal_error [49], zero fill [55:50]
  output logic [55:0]      m_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);
  import hcomp_pkg::*;

  // path lengths behind the front stages
  localparam int unsigned HEAD_LEN = NORM_STEPS + ANGLE_STAGES;
  localparam int unsigned DIV_LEN  = QUO_W;
  localparam int unsigned MID_LEN  = (HEAD_LEN > DIV_LEN) ? HEAD_LEN : DIV_LEN;
  localparam int unsigned PAD_H    = MID_LEN - HEAD_LEN;
  localparam int unsigned PAD_D    = MID_LEN - DIV_LEN;
  localparam int unsigned LAT      = 3 + MID_LEN + 1;

  // span registers
  logic signed [RAW_W-1:0] x_low_q, x_high_q, y_low_q, y_high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_low_q  <= 16'sh8000;
      x_high_q <= 16'sh7fff;
      y_low_q  <= 16'sh8000;
      y_high_q <= 16'sh7fff;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_X_LOW:  x_low_q  <= cfg_data_i;
        REG_X_HIGH: x_high_q <= cfg_data_i;
        REG_Y_LOW:  y_low_q  <= cfg_data_i;
        REG_Y_HIGH: y_high_q <= cfg_data_i;
      endcase
    end
  end

  // global advance: the row moves unless the output register is stuck
  logic adv, accept;
  logic [LAT-1:0] vld_q;

  assign adv           = !vld_q[LAT-1] || m_axis_tready;
  assign accept        = s_axis_tvalid && adv;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[LAT-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[LAT-2:0], accept};
    end
  end

  // front: mapping offsets, cross products
  front_t front_w;

  hcomp_front u_front (
    .clk_i    (clk_i),
    .en_i     (adv),
    .raw_x_i  (s_axis_tdata[15:0]),
    .raw_y_i  (s_axis_tdata[31:16]),
    .x_low_i  (x_low_q),
    .x_high_i (x_high_q),
    .y_low_i  (y_low_q),
    .y_high_i (y_high_q),
    .front_o  (front_w)
  );

  // normalizer row: shifts of 32, 16, 8, 4, 2, 1
  norm_t norm_w [NORM_STEPS+1];

  assign norm_w[0].ax   = NORM_W'(front_w.ax);
  assign norm_w[0].ay   = NORM_W'(front_w.ay);
  assign norm_w[0].side = front_w.side;

  for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
    hcomp_norm_cell #(
      .SHIFT ((1 << (NORM_STEPS - 1)) >> k)
    ) u_norm (
      .clk_i  (clk_i),
      .en_i   (adv),
      .norm_i (norm_w[k]),
      .norm_o (norm_w[k+1])
    );
  end

  // arctangent row
  cord_t cord_w [ANGLE_STAGES+1];

  assign cord_w[0].x    = CORD_W'(norm_w[NORM_STEPS].ax);
  assign cord_w[0].y    = CORD_W'(norm_w[NORM_STEPS].ay);
  assign cord_w[0].z    = '0;
  assign cord_w[0].side = norm_w[NORM_STEPS].side;

  for (genvar k = 0; k < ANGLE_STAGES; k++) begin : g_cordic
    hcomp_cordic_cell #(
      .STAGE (k)
    ) u_cordic (
      .clk_i  (clk_i),
      .en_i   (adv),
      .cord_i (cord_w[k]),
      .cord_o (cord_w[k+1])
    );
  end

  // divider rows for the rounded mapped axes, msb first
  div_t divx_w [QUO_W+1];
  div_t divy_w [QUO_W+1];

  assign divx_w[0].rem = REM_W'(front_w.nx);
  assign divx_w[0].den = front_w.dx;
  assign divx_w[0].quo = '0;
  assign divx_w[0].ovf = front_w.ovf_x;
  assign divy_w[0].rem = REM_W'(front_w.ny);
  assign divy_w[0].den = front_w.dy;
  assign divy_w[0].quo = '0;
  assign divy_w[0].ovf = front_w.ovf_y;

  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    hcomp_div_cell #(
      .BIT (QUO_W - 1 - k)
    ) u_div_x (
      .clk_i (clk_i),
      .en_i  (adv),
      .div_i (divx_w[k]),
      .div_o (divx_w[k+1])
    );
    hcomp_div_cell #(
      .BIT (QUO_W - 1 - k)
    ) u_div_y (
      .clk_i (clk_i),
      .en_i  (adv),
      .div_i (divy_w[k]),
      .div_o (divy_w[k+1])
    );
  end

  // align the shorter path
  cord_t hpad_w [PAD_H+1];
  div_t  xpad_w [PAD_D+1];
  div_t  ypad_w [PAD_D+1];

  assign hpad_w[0] = cord_w[ANGLE_STAGES];
  assign xpad_w[0] = divx_w[QUO_W];
  assign ypad_w[0] = divy_w[QUO_W];

  for (genvar p = 0; p < PAD_H; p++) begin : g_hpad
    always_ff @(posedge clk_i) begin
      if (adv) begin
        hpad_w[p+1] <= hpad_w[p];
      end
    end
  end

  for (genvar p = 0; p < PAD_D; p++) begin : g_dpad
    always_ff @(posedge clk_i) begin
      if (adv) begin
        xpad_w[p+1] <= xpad_w[p];
        ypad_w[p+1] <= ypad_w[p];
      end
    end
  end

  // final stage: round the angle, place it in its quadrant
  cord_t                  fin;
  logic [ANG_W-1:0]       zc, zsum;
  logic [ANG_W-ANG_FRAC-1:0] zr;
  logic [QANG_W-1:0]      acord, qang;
  logic [HEAD_W-1:0]      head, head_w;
  logic [16:0]            calx, caly;

  // rounded quotient to signed 16 bits, sat flag on top
  function automatic logic [16:0] cal_value(logic neg, logic ovf, logic [QUO_W-1:0] q);
    logic [16:0] r;
    if (neg) begin
      if (ovf || q > 16'd32768) r = {1'b1, 16'h8000};
      else                      r = {1'b0, 16'(-q)};
    end else begin
      if (ovf || q > 16'd32767) r = {1'b1, 16'h7fff};
      else                      r = {1'b0, q};
    end
    return r;
  endfunction

  assign fin   = hpad_w[PAD_H];
  assign zc    = fin.z[ANG_W-1] ? '0 : fin.z;
  assign zsum  = zc + ANG_ROUND;
  assign zr    = zsum[ANG_W-1:ANG_FRAC];
  assign acord = (zr > ANG_W'(QANG_MAX)) ? QANG_MAX : zr[QANG_W-1:0];

  always_comb begin
    // vector on an axis is taken exactly
    if (fin.side.zero_x && fin.side.zero_y) qang = '0;
    else if (fin.side.zero_x)               qang = QANG_MAX;
    else if (fin.side.zero_y)               qang = '0;
    else                                    qang = acord;

    if (!fin.side.neg_x && !fin.side.neg_y)     head = HEAD_W'(qang);
    else if (fin.side.neg_x && !fin.side.neg_y) head = HEAD_HALF - HEAD_W'(qang);
    else if (fin.side.neg_x)                    head = HEAD_HALF + HEAD_W'(qang);
    else                                        head = HEAD_FULL - HEAD_W'(qang);

    // full turn wraps to zero
    head_w = (head >= HEAD_FULL) ? '0 : head;
  end

  assign calx = cal_value(fin.side.neg_x, xpad_w[PAD_D].ovf, xpad_w[PAD_D].quo);
  assign caly = cal_value(fin.side.neg_y, ypad_w[PAD_D].ovf, ypad_w[PAD_D].quo);

  logic [55:0] out_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (fin.side.err) begin
        // degenerate span: everything zero, error flag only
        out_q <= {6'd0, 1'b1, 49'd0};
      end else begin
        out_q <= {6'd0, 1'b0, calx[16] | caly[16], caly[15:0], calx[15:0], head_w};
      end
    end
  end

  assign m_axis_tdata = out_q;

endmodule
`default_nettype wire

// ===== bench/compass_heading_from_magnetometer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// compass_heading_from_magnetometer_test
// drives raw magnetometer samples under several span settings, predicts the
// heading and the mapped axes for each accepted request and checks every
// result in order, with random gaps and stalls on both streams
// ----------------------------------------------------------------------------
module compass_heading_from_magnetometer_test;
  import hcomp_pkg::*;

  localparam int unsigned STALL_LIMIT = 3000;   // cycles with no transfer at all
  localparam int unsigned DRAIN_WAIT  = 40;     // idle wait after the queues drain
  localparam int unsigned HOLD_CYCLES = 400;    // long receiver hold-off

  typedef struct packed {
    logic [15:0] heading;
    logic [15:0] cal_x;
    logic [15:0] cal_y;
    logic        sat;
    logic        err;
  } heading_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = REG_X_LOW;
  logic [15:0] cfg_data_i = '0;

  // span registers as the predictor sees them
  logic signed [15:0] span_xl = -16'sd32768, span_xh = 16'sd32767;
  logic signed [15:0] span_yl = -16'sd32768, span_yh = 16'sd32767;

  logic [31:0]  sample_q [$];
  heading_res_t heading_q [$];
  int unsigned  errors = 0;
  bit           quiet = 1'b0;    // no idling in the last part
  bit           hold_req = 1'b0;
  int unsigned  send_gap = 0, recv_gap = 0, hold_cnt = 0, stall_cnt = 0;

  compass_heading_from_magnetometer dut (
    .clk_i, .rst_ni, .s_axis_tdata, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tdata, .m_axis_tvalid, .m_axis_tready, .cfg_we_i, .cfg_idx_i,
    .cfg_data_i
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // round half away from zero, clip to 16 bits
  function automatic longint round_clip(longint num, longint den, inout bit sat);
    longint unsigned mag;
    longint unsigned q;
    longint r;
    mag = (num < 0) ? -num : num;
    q = (mag * 2 + den) / (den * 2);
    r = (num < 0) ? -longint'(q) : longint'(q);
    if (r > 32767) begin
      sat = 1'b1;
      r = 32767;
    end else if (r < -32768) begin
      sat = 1'b1;
      r = -32768;
    end
    return r;
  endfunction

  // vectoring rotation, first quadrant, centidegrees 0..9000
  function automatic longint quadrant_centideg(longint unsigned ax, longint unsigned ay);
    longint unsigned m;
    longint x, y, z, dx, dy;
    m = (ax > ay) ? ax : ay;
    z = 0;
    while (m < (64'd1 << 59)) begin
      m = m << 1;
      ax = ax << 1;
      ay = ay << 1;
    end
    x = ax;
    y = ay;
    for (int i = 0; i < ANGLE_STAGES_DEF; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(ARC_TABLE[i]);
      end else begin
        x -= dx; y += dy; z -= longint'(ARC_TABLE[i]);
      end
    end
    if (z < 0) z = 0;
    z = (z + 32768) >>> 16;
    return (z > 9000) ? 9000 : z;
  endfunction

  function automatic heading_res_t predict_heading(logic [31:0] d);
    longint rx, ry, xd, yd, xn, yn, cx, cy, vx, vy, a, head;
    longint unsigned ax, ay;
    bit sat;
    heading_res_t r;
    sat = 1'b0;
    r = '0;
    rx = longint'($signed(d[15:0]));
    ry = longint'($signed(d[31:16]));
    xd = longint'(span_xh) - longint'(span_xl);
    yd = longint'(span_yh) - longint'(span_yl);
    if (xd == 0 || yd == 0) begin
      r.err = 1'b1;
      return r;
    end
    xn = (rx - span_xl) * 2000 - 1000 * xd;
    yn = (ry - span_yl) * 2000 - 1000 * yd;
    // reversed span: flip sign so the denominator stays positive
    if (xd < 0) begin xd = -xd; xn = -xn; end
    if (yd < 0) begin yd = -yd; yn = -yn; end
    cx = round_clip(xn, xd, sat);
    cy = round_clip(yn, yd, sat);
    vx = xn * yd;
    vy = yn * xd;
    ax = (vx < 0) ? -vx : vx;
    ay = (vy < 0) ? -vy : vy;
    if (ax == 0) a = (ay == 0) ? 0 : 9000;
    else if (ay == 0) a = 0;
    else a = quadrant_centideg(ax, ay);
    if (vx >= 0 && vy >= 0) head = a;
    else if (vx < 0 && vy >= 0) head = 18000 - a;
    else if (vx < 0) head = 18000 + a;
    else head = 36000 - a;
    if (head >= 36000) head -= 36000;   // rounds up to a full turn
    r.heading = head[15:0];
    r.cal_x = cx[15:0];
    r.cal_y = cy[15:0];
    r.sat = sat;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // driver: feeds queued samples, predicts on each accepted request
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) heading_q.push_back(predict_heading(s_axis_tdata));
    if (!s_axis_tvalid || s_axis_tready) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (sample_q.size() > 0) begin
        s_axis_tdata <= sample_q.pop_front();
        s_axis_tvalid <= 1'b1;
        if (!quiet && $urandom_range(15) == 0) send_gap <= $urandom_range(19, 1);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver ready: random stalls plus one long hold-off
  always @(posedge clk_i) begin
    if (hold_req && hold_cnt == 0) hold_cnt <= HOLD_CYCLES;
    if (hold_cnt > 1 || (hold_req && hold_cnt == 0)) begin
      m_axis_tready <= 1'b0;
      if (hold_cnt > 1) hold_cnt <= hold_cnt - 1;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (!quiet && $urandom_range(15) == 0) recv_gap <= $urandom_range(19, 1);
    end
  end

  // monitor: compare each result with the oldest prediction
  always @(posedge clk_i) begin
    heading_res_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (heading_q.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata[15:0], 16'd0);
      end else begin
        want = heading_q.pop_front();
        if (m_axis_tdata[15:0] !== want.heading)
          report_mismatch("heading", m_axis_tdata[15:0], want.heading);
        if (m_axis_tdata[31:16] !== want.cal_x)
          report_mismatch("cal_x", m_axis_tdata[31:16], want.cal_x);
        if (m_axis_tdata[47:32] !== want.cal_y)
          report_mismatch("cal_y", m_axis_tdata[47:32], want.cal_y);
        if (m_axis_tdata[48] !== want.sat)
          report_mismatch("cal_saturated", 16'(m_axis_tdata[48]), 16'(want.sat));
        if (m_axis_tdata[49] !== want.err)
          report_mismatch("cal_error", 16'(m_axis_tdata[49]), 16'(want.err));
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i)
      stall_cnt <= 0;
    else if (rst_ni) stall_cnt <= stall_cnt + 1;
    if (stall_cnt >= STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic wait_idle();
    wait (sample_q.size() == 0 && heading_q.size() == 0 && !s_axis_tvalid);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  // four back-to-back register writes, enable dropped once at the end
  task automatic load_spans(logic [15:0] xl, logic [15:0] xh, logic [15:0] yl,
                            logic [15:0] yh);
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= REG_X_LOW; cfg_data_i <= xl;
    @(posedge clk_i);
    cfg_idx_i <= REG_X_HIGH; cfg_data_i <= xh;
    @(posedge clk_i);
    cfg_idx_i <= REG_Y_LOW; cfg_data_i <= yl;
    @(posedge clk_i);
    cfg_idx_i <= REG_Y_HIGH; cfg_data_i <= yh;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    span_xl = xl; span_xh = xh; span_yl = yl; span_yh = yh;
  endtask

  function automatic logic [15:0] pick_raw(logic signed [15:0] lo, logic signed [15:0] hi);
    int a, b;
    a = (lo < hi) ? lo : hi;
    b = (lo < hi) ? hi : lo;
    if ($urandom_range(9) < 7) return 16'(a + int'($urandom_range(b - a)));
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_span_end();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed(11'($urandom)));    // narrow around zero
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] a, b, c, e;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset spans: field extremes, tiny negative y rounds to a full turn
    sample_q.push_back({16'h8000, 16'h8000});
    sample_q.push_back({16'h7fff, 16'h7fff});
    sample_q.push_back({16'h7fff, 16'h8000});
    sample_q.push_back({16'h8000, 16'h7fff});
    sample_q.push_back({16'hffff, 16'h7fff});
    sample_q.push_back({16'h0000, 16'h7fff});
    wait_idle();

    // symmetric narrow span: zero vector, axes, saturation
    load_spans(-16'sd100, 16'sd100, -16'sd100, 16'sd100);
    sample_q.push_back({16'd0, 16'd0});
    sample_q.push_back({16'd0, 16'd100});
    sample_q.push_back({16'd100, 16'd0});
    sample_q.push_back({16'd0, -16'sd100});
    sample_q.push_back({-16'sd100, 16'd0});
    sample_q.push_back({16'h8000, 16'h7fff});
    sample_q.push_back({16'h7fff, 16'h8000});
    sample_q.push_back({16'd1, 16'd1});
    wait_idle();

    // reversed full range and equal span ends
    load_spans(16'h7fff, 16'h8000, 16'h7fff, 16'h8000);
    sample_q.push_back({16'h8000, 16'h7fff});
    sample_q.push_back({16'h1234, 16'hedcb});
    wait_idle();
    load_spans(16'h8000, 16'h8000, -16'sd5, 16'sd5);
    sample_q.push_back({16'd3, 16'd7});
    sample_q.push_back({16'hffff, 16'hffff});
    wait_idle();
    load_spans(-16'sd5, 16'sd5, 16'h7fff, 16'h7fff);
    sample_q.push_back({16'd3, 16'd7});
    wait_idle();

    // random phases with random spans
    for (int ph = 0; ph < 8; ph++) begin
      a = pick_span_end(); b = pick_span_end();
      c = pick_span_end(); e = pick_span_end();
      if ($urandom_range(9) == 0) b = a;
      load_spans(a, b, c, e);
      if (ph == 7) quiet = 1'b1;
      for (int i = 0; i < 170; i++) begin
        sample_q.push_back({pick_raw(span_yl, span_yh), pick_raw(span_xl, span_xh)});
        if (ph == 3 && i == 20) begin
          // input keeps being offered while the output holds off
          hold_req = 1'b1;
          wait (hold_cnt > 1);
          hold_req = 1'b0;
        end
      end
      wait_idle();
    end

    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
